@@ src/lacb_pkg.sv @@
// ----------------------------------------------------------------------------
// lacb_pkg
// Shared types and constants for the look-at camera basis pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lacb_pkg;

    // Q1.14 value of one, used for fallback vectors and the quotient cap.
    localparam logic signed [15:0] Q14_ONE      = 16'sd16384;
    localparam logic signed [15:0] Q14_NEG_ONE  = -16'sd16384;

    // Threshold register reset value, in units of 2^-32.
    localparam logic [31:0] MIN_LEN_SQ_RESET = 32'd429497;

    // Input transaction: camera position and target, Q16.16.
    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } lacb_in_t;

    // Result transaction: three Q1.14 unit vectors and two fallback flags.
    typedef struct packed {
        logic signed [15:0] facing_x;
        logic signed [15:0] facing_y;
        logic signed [15:0] facing_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic               facing_fallback;
        logic               right_fallback;
    } lacb_out_t;

    // Wide vector entering a normalizer (difference, right or cross product).
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } lacb_wide_vec_t;

    // Q1.14 unit vector.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } lacb_unit_vec_t;

    // Partial results that travel alongside a vector through a normalizer.
    typedef struct packed {
        lacb_unit_vec_t facing;
        lacb_unit_vec_t right;
        logic           facing_fallback;
        logic           right_fallback;
    } lacb_side_t;

    // Valid bit and side data of one pipeline slot.
    typedef struct packed {
        logic       valid;
        lacb_side_t side;
    } lacb_tag_t;

endpackage

`default_nettype wire

@@ src/lacb_norm3.sv @@
// ----------------------------------------------------------------------------
// lacb_norm3
// Pipelined normalizer: scales a 3-vector to Q1.14 unit length with a
// block shift, a 32-step square root and three 15-step dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module lacb_norm3 (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lacb_pkg::lacb_tag_t      in_tag,
    input  lacb_pkg::lacb_wide_vec_t in_vec,
    output lacb_pkg::lacb_tag_t      out_tag,
    output lacb_pkg::lacb_unit_vec_t out_vec
);
    import lacb_pkg::*;

    localparam int LANES       = 3;
    localparam int IN_W        = 33;
    localparam int M_W         = 31;
    localparam int FIRST_SHIFT = 16;
    localparam int FRAC_W      = 14;
    localparam int ROOT_W      = 32;
    localparam int QUO_W       = 15;
    localparam int NUM_W       = M_W + FRAC_W + 1;

    // Stage numbers along the pipeline.
    localparam int SHIFT_LAST = 6;
    localparam int SQ_STG     = SHIFT_LAST + 1;
    localparam int SUM_STG    = SQ_STG + 2;
    localparam int ROOT_FIRST = SUM_STG + 1;
    localparam int ROOT_LAST  = ROOT_FIRST + ROOT_W - 1;
    localparam int NUM_STG    = ROOT_LAST + 1;
    localparam int DIV_FIRST  = NUM_STG + 1;
    localparam int DIV_LAST   = DIV_FIRST + QUO_W - 1;
    localparam int OUT_STG    = DIV_LAST + 1;

    localparam logic [QUO_W-1:0] QUO_CAP = QUO_W'(Q14_ONE);

    logic                     valid_reg [0:OUT_STG];
    lacb_side_t               side_reg  [0:OUT_STG];
    logic [3:0]               flag_reg  [0:OUT_STG];

    logic [IN_W-1:0]          mag_reg   [0:LANES-1];
    logic [M_W-1:0]           m_reg     [1:ROOT_LAST][0:LANES-1];
    logic [M_W-1:0]           mx_reg    [1:SHIFT_LAST];
    logic [2*M_W-1:0]         sq_reg    [0:LANES-1];
    logic [2*M_W:0]           s01_reg;
    logic [2*M_W-1:0]         sq2_reg;
    logic [2*ROOT_W-1:0]      x_reg     [SUM_STG:ROOT_LAST-1];
    logic [ROOT_W:0]          rem_reg   [SUM_STG:ROOT_LAST];
    logic [ROOT_W-1:0]        root_reg  [SUM_STG:ROOT_LAST];
    logic [NUM_W-1:0]         num_reg   [NUM_STG:DIV_LAST-1][0:LANES-1];
    logic [ROOT_W-1:0]        r_reg     [NUM_STG:DIV_LAST-1];
    logic [ROOT_W-1:0]        drem_reg  [NUM_STG:DIV_LAST][0:LANES-1];
    logic [QUO_W-1:0]         quo_reg   [NUM_STG:DIV_LAST][0:LANES-1];
    lacb_unit_vec_t           out_reg;

    logic signed [IN_W-1:0]   in_comp   [0:LANES-1];
    logic [IN_W-1:0]          in_mag    [0:LANES-1];
    logic                     in_zero;
    logic [IN_W-1:0]          rsh_mx;
    logic [M_W-1:0]           rsh_m_next  [0:LANES-1];
    logic [M_W-1:0]           rsh_mx_next;
    logic [ROOT_W:0]          root_rem_next [ROOT_FIRST:ROOT_LAST];
    logic [ROOT_W-1:0]        root_q_next   [ROOT_FIRST:ROOT_LAST];
    logic [NUM_W-1:0]         num_next  [0:LANES-1];
    logic [ROOT_W-1:0]        div_rem_next [DIV_FIRST:DIV_LAST][0:LANES-1];
    logic [QUO_W-1:0]         div_q_next   [DIV_FIRST:DIV_LAST][0:LANES-1];
    lacb_unit_vec_t           out_next;

    // Component magnitudes and the zero test.
    assign in_comp[0] = in_vec.x;
    assign in_comp[1] = in_vec.y;
    assign in_comp[2] = in_vec.z;
    assign in_zero    = (in_vec == '0);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            in_mag[l] = in_comp[l][IN_W-1] ? IN_W'(-in_comp[l]) : IN_W'(in_comp[l]);
        end
    end

    // Largest magnitude, then a right shift that brings it below 2^31.
    always_comb
    begin
        rsh_mx = mag_reg[0];
        if (mag_reg[1] > rsh_mx)
        begin
            rsh_mx = mag_reg[1];
        end
        if (mag_reg[2] > rsh_mx)
        begin
            rsh_mx = mag_reg[2];
        end
        for (int l = 0; l < LANES; l++)
        begin
            if (rsh_mx[IN_W-1])
            begin
                rsh_m_next[l] = M_W'(mag_reg[l] >> 2);
            end
            else if (rsh_mx[IN_W-2])
            begin
                rsh_m_next[l] = M_W'(mag_reg[l] >> 1);
            end
            else
            begin
                rsh_m_next[l] = M_W'(mag_reg[l]);
            end
        end
        if (rsh_mx[IN_W-1])
        begin
            rsh_mx_next = M_W'(rsh_mx >> 2);
        end
        else if (rsh_mx[IN_W-2])
        begin
            rsh_mx_next = M_W'(rsh_mx >> 1);
        end
        else
        begin
            rsh_mx_next = M_W'(rsh_mx);
        end
    end

    // Square root steps: one result bit per stage, two radicand bits down.
    always_comb
    begin
        logic [1:0]        pair;
        logic [ROOT_W+2:0] trial_rem;
        logic [ROOT_W+2:0] trial_sub;
        for (int k = ROOT_FIRST; k <= ROOT_LAST; k++)
        begin
            pair      = 2'(x_reg[k-1] >> (2 * (ROOT_LAST - k)));
            trial_rem = {rem_reg[k-1], pair};
            trial_sub = {1'b0, root_reg[k-1], 2'b01};
            if (trial_rem >= trial_sub)
            begin
                root_rem_next[k] = (ROOT_W+1)'(trial_rem - trial_sub);
                root_q_next[k]   = {root_reg[k-1][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                root_rem_next[k] = (ROOT_W+1)'(trial_rem);
                root_q_next[k]   = {root_reg[k-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Rounded dividend: component scaled to Q14 plus half the root.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            num_next[l] = NUM_W'({m_reg[ROOT_LAST][l], FRAC_W'(0)})
                        + NUM_W'(root_reg[ROOT_LAST] >> 1);
        end
    end

    // Long division steps, one quotient bit per stage in each lane.
    always_comb
    begin
        logic [ROOT_W:0] part;
        for (int k = DIV_FIRST; k <= DIV_LAST; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                part = {drem_reg[k-1][l], num_reg[k-1][l][DIV_LAST - k]};
                if (part >= {1'b0, r_reg[k-1]})
                begin
                    div_rem_next[k][l] = ROOT_W'(part - {1'b0, r_reg[k-1]});
                    div_q_next[k][l]   = {quo_reg[k-1][l][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next[k][l] = ROOT_W'(part);
                    div_q_next[k][l]   = {quo_reg[k-1][l][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Cap, sign and zero handling of the final quotients.
    always_comb
    begin
        logic [QUO_W-1:0]   capped;
        logic signed [15:0] comp [0:LANES-1];
        for (int l = 0; l < LANES; l++)
        begin
            capped = (quo_reg[DIV_LAST][l] > QUO_CAP) ? QUO_CAP : quo_reg[DIV_LAST][l];
            if (flag_reg[DIV_LAST][3])
            begin
                comp[l] = '0;
            end
            else if (flag_reg[DIV_LAST][l])
            begin
                comp[l] = -$signed(16'(capped));
            end
            else
            begin
                comp[l] = $signed(16'(capped));
            end
        end
        out_next.x = comp[0];
        out_next.y = comp[1];
        out_next.z = comp[2];
    end

    // Valid bits of the slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= OUT_STG; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_tag.valid;
            for (int s = 1; s <= OUT_STG; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // Data path registers of all stages.
    always_ff @(posedge clk)
    begin
        int sh;
        side_reg[0] <= in_tag.side;
        flag_reg[0] <= {in_zero, in_comp[2][IN_W-1], in_comp[1][IN_W-1], in_comp[0][IN_W-1]};
        for (int s = 1; s <= OUT_STG; s++)
        begin
            side_reg[s] <= side_reg[s-1];
            flag_reg[s] <= flag_reg[s-1];
        end

        for (int l = 0; l < LANES; l++)
        begin
            mag_reg[l]  <= in_mag[l];
            m_reg[1][l] <= rsh_m_next[l];
        end
        mx_reg[1] <= rsh_mx_next;

        // Left shifts by 16, 8, 4, 2 and 1 until bit 30 of the largest is set.
        for (int s = 2; s <= SHIFT_LAST; s++)
        begin
            sh = FIRST_SHIFT >> (s - 2);
            if ((mx_reg[s-1] >> (M_W - sh)) == '0)
            begin
                mx_reg[s] <= mx_reg[s-1] << sh;
                for (int l = 0; l < LANES; l++)
                begin
                    m_reg[s][l] <= m_reg[s-1][l] << sh;
                end
            end
            else
            begin
                mx_reg[s] <= mx_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    m_reg[s][l] <= m_reg[s-1][l];
                end
            end
        end
        for (int s = SHIFT_LAST + 1; s <= ROOT_LAST; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                m_reg[s][l] <= m_reg[s-1][l];
            end
        end

        // Sum of squares over two stages.
        for (int l = 0; l < LANES; l++)
        begin
            sq_reg[l] <= (2*M_W)'(m_reg[SHIFT_LAST][l]) * (2*M_W)'(m_reg[SHIFT_LAST][l]);
        end
        s01_reg <= (2*M_W+1)'(sq_reg[0]) + (2*M_W+1)'(sq_reg[1]);
        sq2_reg <= sq_reg[2];
        x_reg[SUM_STG]    <= (2*ROOT_W)'(s01_reg) + (2*ROOT_W)'(sq2_reg);
        rem_reg[SUM_STG]  <= '0;
        root_reg[SUM_STG] <= '0;

        for (int k = ROOT_FIRST; k <= ROOT_LAST; k++)
        begin
            rem_reg[k]  <= root_rem_next[k];
            root_reg[k] <= root_q_next[k];
        end
        for (int k = ROOT_FIRST; k < ROOT_LAST; k++)
        begin
            x_reg[k] <= x_reg[k-1];
        end

        r_reg[NUM_STG] <= root_reg[ROOT_LAST];
        for (int l = 0; l < LANES; l++)
        begin
            num_reg[NUM_STG][l]  <= num_next[l];
            drem_reg[NUM_STG][l] <= ROOT_W'(num_next[l] >> QUO_W);
            quo_reg[NUM_STG][l]  <= '0;
        end
        for (int k = DIV_FIRST; k <= DIV_LAST; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                drem_reg[k][l] <= div_rem_next[k][l];
                quo_reg[k][l]  <= div_q_next[k][l];
            end
        end
        for (int k = DIV_FIRST; k < DIV_LAST; k++)
        begin
            r_reg[k] <= r_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[k][l] <= num_reg[k-1][l];
            end
        end

        out_reg <= out_next;
    end

    assign out_tag.valid = valid_reg[OUT_STG];
    assign out_tag.side  = side_reg[OUT_STG];
    assign out_vec       = out_reg;

endmodule

`default_nettype wire

@@ src/look_at_camera_basis.sv @@
// ----------------------------------------------------------------------------
// look_at_camera_basis
// Builds an orthonormal look-at basis (facing, right, up) in Q1.14 from a
// Q16.16 camera position and target.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge with start high; busy is always
// low, so a new pose may be issued each cycle. Each result is shown for
// exactly one cycle with done high, in issue order. Each pose passes through
// three normalizers in series (facing, right, up), each with a 32-stage square
// root and a 15-stage divider; the results must be taken as they come. The
// user must write min_length_squared with cfg_we only while no transaction is
// in flight; the block itself does not enforce this.
`default_nettype none

module look_at_camera_basis (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lacb_pkg::lacb_in_t  request,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    output logic                done,
    output lacb_pkg::lacb_out_t result
);
    import lacb_pkg::*;

    logic [31:0]      thr_reg;

    logic             a_valid_reg, b_valid_reg, c_valid_reg;
    logic             d_valid_reg, e_valid_reg, f_valid_reg, g_valid_reg;
    logic             done_reg;

    lacb_wide_vec_t   a_d_reg, b_d_reg, c_d_reg;
    logic [31:0]      b_sq_reg [0:2];
    logic             b_small_reg, b_zero_reg, c_ffb_reg;
    lacb_unit_vec_t   d_f_reg;
    lacb_side_t       d_side_reg;
    logic [28:0]      d_sqx_reg, d_sqz_reg;
    lacb_wide_vec_t   e_vec_reg;
    lacb_side_t       e_side_reg, f_side_reg, g_side_reg;
    logic signed [31:0] f_prod_reg [0:5];
    lacb_wide_vec_t   g_vec_reg;
    lacb_out_t        result_reg;

    logic [32:0]      b_mag [0:2];
    logic [33:0]      c_sum;
    lacb_unit_vec_t   d_f_next;
    logic             e_rfb_next;
    lacb_unit_vec_t   f_rt_next;

    lacb_tag_t        n1_in_tag, n2_in_tag, n3_in_tag;
    lacb_tag_t        n1_out_tag, n2_out_tag, n3_out_tag;
    lacb_unit_vec_t   n1_vec, n2_vec, n3_vec;

    assign busy = 1'b0;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= MIN_LEN_SQ_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Valid bits of the front and glue stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start & ~busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= n1_out_tag.valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= n2_out_tag.valid;
            g_valid_reg <= f_valid_reg;
            done_reg    <= n3_out_tag.valid;
        end
    end

    // Facing degeneracy: any component of 2^16 or more already exceeds the
    // 32-bit threshold, so only small differences need their squares.
    always_comb
    begin
        b_mag[0] = a_d_reg.x[32] ? 33'(-a_d_reg.x) : 33'(a_d_reg.x);
        b_mag[1] = a_d_reg.y[32] ? 33'(-a_d_reg.y) : 33'(a_d_reg.y);
        b_mag[2] = a_d_reg.z[32] ? 33'(-a_d_reg.z) : 33'(a_d_reg.z);
        c_sum    = 34'(b_sq_reg[0]) + 34'(b_sq_reg[1]) + 34'(b_sq_reg[2]);
    end

    // Facing with its fallback, and right's squared length.
    always_comb
    begin
        if (n1_out_tag.side.facing_fallback)
        begin
            d_f_next.x = '0;
            d_f_next.y = '0;
            d_f_next.z = Q14_NEG_ONE;
        end
        else
        begin
            d_f_next = n1_vec;
        end
        e_rfb_next = ((d_f_reg.x == '0) && (d_f_reg.z == '0))
                   || ({30'(d_sqx_reg) + 30'(d_sqz_reg), 4'b0000} < 34'(thr_reg));
    end

    // Right with its fallback.
    always_comb
    begin
        if (n2_out_tag.side.right_fallback)
        begin
            f_rt_next.x = Q14_ONE;
            f_rt_next.y = '0;
            f_rt_next.z = '0;
        end
        else
        begin
            f_rt_next = n2_vec;
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        a_d_reg.x <= 33'(request.target_x) - 33'(request.position_x);
        a_d_reg.y <= 33'(request.target_y) - 33'(request.position_y);
        a_d_reg.z <= 33'(request.target_z) - 33'(request.position_z);

        b_d_reg     <= a_d_reg;
        b_zero_reg  <= (a_d_reg == '0);
        b_small_reg <= (b_mag[0][32:16] == '0) && (b_mag[1][32:16] == '0)
                    && (b_mag[2][32:16] == '0);
        for (int l = 0; l < 3; l++)
        begin
            b_sq_reg[l] <= 32'(b_mag[l][15:0]) * 32'(b_mag[l][15:0]);
        end

        c_d_reg   <= b_d_reg;
        c_ffb_reg <= b_zero_reg || (b_small_reg && (c_sum < 34'(thr_reg)));

        d_f_reg    <= d_f_next;
        d_side_reg <= n1_out_tag.side;
        d_sqx_reg  <= 29'(32'(d_f_next.x) * 32'(d_f_next.x));
        d_sqz_reg  <= 29'(32'(d_f_next.z) * 32'(d_f_next.z));

        // Right before normalizing is facing x world up: (-fz, 0, fx).
        e_vec_reg.x                <= -33'(d_f_reg.z);
        e_vec_reg.y                <= '0;
        e_vec_reg.z                <= 33'(d_f_reg.x);
        e_side_reg.facing          <= d_f_reg;
        e_side_reg.right           <= '0;
        e_side_reg.facing_fallback <= d_side_reg.facing_fallback;
        e_side_reg.right_fallback  <= e_rfb_next;

        // Up before normalizing is right x facing.
        f_prod_reg[0]    <= 32'(f_rt_next.y) * 32'(n2_out_tag.side.facing.z);
        f_prod_reg[1]    <= 32'(f_rt_next.z) * 32'(n2_out_tag.side.facing.y);
        f_prod_reg[2]    <= 32'(f_rt_next.z) * 32'(n2_out_tag.side.facing.x);
        f_prod_reg[3]    <= 32'(f_rt_next.x) * 32'(n2_out_tag.side.facing.z);
        f_prod_reg[4]    <= 32'(f_rt_next.x) * 32'(n2_out_tag.side.facing.y);
        f_prod_reg[5]    <= 32'(f_rt_next.y) * 32'(n2_out_tag.side.facing.x);
        f_side_reg.facing          <= n2_out_tag.side.facing;
        f_side_reg.right           <= f_rt_next;
        f_side_reg.facing_fallback <= n2_out_tag.side.facing_fallback;
        f_side_reg.right_fallback  <= n2_out_tag.side.right_fallback;

        g_vec_reg.x <= 33'(f_prod_reg[0]) - 33'(f_prod_reg[1]);
        g_vec_reg.y <= 33'(f_prod_reg[2]) - 33'(f_prod_reg[3]);
        g_vec_reg.z <= 33'(f_prod_reg[4]) - 33'(f_prod_reg[5]);
        g_side_reg  <= f_side_reg;

        result_reg.facing_x        <= n3_out_tag.side.facing.x;
        result_reg.facing_y        <= n3_out_tag.side.facing.y;
        result_reg.facing_z        <= n3_out_tag.side.facing.z;
        result_reg.right_x         <= n3_out_tag.side.right.x;
        result_reg.right_y         <= n3_out_tag.side.right.y;
        result_reg.right_z         <= n3_out_tag.side.right.z;
        result_reg.up_x            <= n3_vec.x;
        result_reg.up_y            <= n3_vec.y;
        result_reg.up_z            <= n3_vec.z;
        result_reg.facing_fallback <= n3_out_tag.side.facing_fallback;
        result_reg.right_fallback  <= n3_out_tag.side.right_fallback;
    end

    // Facing normalizer.
    always_comb
    begin
        n1_in_tag.valid                = c_valid_reg;
        n1_in_tag.side                 = '0;
        n1_in_tag.side.facing_fallback = c_ffb_reg;
    end

    lacb_norm3 u_norm_facing (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (n1_in_tag),
        .in_vec  (c_d_reg),
        .out_tag (n1_out_tag),
        .out_vec (n1_vec)
    );

    // Right normalizer.
    assign n2_in_tag.valid = e_valid_reg;
    assign n2_in_tag.side  = e_side_reg;

    lacb_norm3 u_norm_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (n2_in_tag),
        .in_vec  (e_vec_reg),
        .out_tag (n2_out_tag),
        .out_vec (n2_vec)
    );

    // Up normalizer.
    assign n3_in_tag.valid = g_valid_reg;
    assign n3_in_tag.side  = g_side_reg;

    lacb_norm3 u_norm_up (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (n3_in_tag),
        .in_vec  (g_vec_reg),
        .out_tag (n3_out_tag),
        .out_vec (n3_vec)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ src/lacb_checker.sv @@
// ----------------------------------------------------------------------------
// lacb_checker
// Port-level checks for the look-at camera basis block.
// ----------------------------------------------------------------------------
`default_nettype none

module lacb_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  lacb_pkg::lacb_in_t  request,
    input  wire                 cfg_we,
    input  wire  [31:0]         cfg_wdata,
    input  wire                 done,
    input  lacb_pkg::lacb_out_t result
);
    import lacb_pkg::*;

    // The pipeline never holds off a transaction.
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy)
        else $error("busy raised while a transaction was offered");

    // A facing fallback result carries exactly (0,0,-1).
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.facing_fallback) |->
        (result.facing_x == '0 && result.facing_y == '0 && result.facing_z == Q14_NEG_ONE))
        else $error("facing fallback with a wrong vector");

    // A right fallback result carries exactly (1,0,0).
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.right_fallback) |->
        (result.right_x == Q14_ONE && result.right_y == '0 && result.right_z == '0))
        else $error("right fallback with a wrong vector");

    // Right is always horizontal.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> (result.right_y == '0))
        else $error("right vector has a vertical component");

endmodule

bind look_at_camera_basis lacb_checker u_lacb_checker (.*);

`default_nettype wire

@@ tb/look_at_camera_basis_tb.sv @@
// ----------------------------------------------------------------------------
// look_at_camera_basis_tb
// Drives camera poses through the look-at basis pipeline under several
// threshold settings and idle patterns, and checks every result against a
// bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module look_at_camera_basis_tb;

    import lacb_pkg::*;

    localparam int LATENCY = 185;
    localparam logic [31:0] LEN_SQ_MAX = 32'hFFFFFFFF;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    lacb_in_t  request;
    logic      cfg_we;
    logic [31:0] cfg_wdata;
    logic      done;
    lacb_out_t result;

    // Threshold copy kept by the predictor.
    logic [31:0] min_len_sq;
    int          sender_idle_pct;
    int          items_sent;
    int          fallback_seen;

    look_at_camera_basis u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    // Integer square root, floor.
    function automatic logic [63:0] isqrt(input logic [63:0] val);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = val;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a vector to Q1.14 unit length; returns 0 for a zero vector.
    function automatic bit to_unit(input longint vx, input longint vy, input longint vz,
                                   output lacb_unit_vec_t u);
        logic [63:0] m [3];
        longint      v [3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] r;
        logic [63:0] q;
        logic signed [15:0] c [3];
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        for (int i = 0; i < 3; i++)
            m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        u = '0;
        if (mx == 0)
            return 0;
        while (mx >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * 64'd16384 + r / 2) / r;
            if (q > 64'd16384)
                q = 64'd16384;
            c[i] = v[i] < 0 ? -16'(q) : 16'(q);
        end
        u.x = c[0];
        u.y = c[1];
        u.z = c[2];
        return 1;
    endfunction

    // Computes the expected basis for one pose.
    function automatic lacb_out_t predict_basis(input lacb_in_t p, input logic [31:0] thr);
        longint d [3];
        logic [63:0] len2;
        logic [63:0] mg;
        logic [63:0] sq;
        lacb_unit_vec_t f;
        lacb_unit_vec_t rt;
        lacb_unit_vec_t up;
        bit ffb;
        bit rfb;
        bit ok;
        lacb_out_t o;
        d[0] = longint'(p.target_x) - longint'(p.position_x);
        d[1] = longint'(p.target_y) - longint'(p.position_y);
        d[2] = longint'(p.target_z) - longint'(p.position_z);
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            mg = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            sq = mg * mg;
            len2 = (len2 + sq < len2) ? 64'hFFFFFFFFFFFFFFFF : len2 + sq;
        end
        ok = to_unit(d[0], d[1], d[2], f);
        ffb = (len2 < 64'(thr)) || !ok;
        if (ffb)
        begin
            f.x = 0;
            f.y = 0;
            f.z = Q14_NEG_ONE;
        end
        len2 = (64'(longint'(f.z) * f.z) + 64'(longint'(f.x) * f.x)) * 16;
        ok = to_unit(-longint'(f.z), 0, longint'(f.x), rt);
        rfb = (len2 < 64'(thr)) || !ok;
        if (rfb)
        begin
            rt.x = Q14_ONE;
            rt.y = 0;
            rt.z = 0;
        end
        void'(to_unit(longint'(rt.y) * f.z - longint'(rt.z) * f.y,
                      longint'(rt.z) * f.x - longint'(rt.x) * f.z,
                      longint'(rt.x) * f.y - longint'(rt.y) * f.x, up));
        o.facing_x = f.x;
        o.facing_y = f.y;
        o.facing_z = f.z;
        o.right_x = rt.x;
        o.right_y = rt.y;
        o.right_z = rt.z;
        o.up_x = up.x;
        o.up_y = up.y;
        o.up_z = up.z;
        o.facing_fallback = ffb;
        o.right_fallback = rfb;
        return o;
    endfunction

    // Holds expected bases in issue order and compares finished ones.
    class basis_scoreboard;
        lacb_out_t pending_bases [$];
        int        errors;
        int        checked;

        function void note_pose(lacb_out_t exp_basis);
            pending_bases.push_back(exp_basis);
        endfunction

        function void check_basis(lacb_out_t got);
            lacb_out_t e;
            if (pending_bases.size() == 0)
            begin
                $error("result with no pose outstanding");
                errors++;
                return;
            end
            e = pending_bases.pop_front();
            checked++;
            if (got.facing_x !== e.facing_x)
                begin $error("facing_x exp %0d got %0d", e.facing_x, got.facing_x); errors++; end
            if (got.facing_y !== e.facing_y)
                begin $error("facing_y exp %0d got %0d", e.facing_y, got.facing_y); errors++; end
            if (got.facing_z !== e.facing_z)
                begin $error("facing_z exp %0d got %0d", e.facing_z, got.facing_z); errors++; end
            if (got.right_x !== e.right_x)
                begin $error("right_x exp %0d got %0d", e.right_x, got.right_x); errors++; end
            if (got.right_y !== e.right_y)
                begin $error("right_y exp %0d got %0d", e.right_y, got.right_y); errors++; end
            if (got.right_z !== e.right_z)
                begin $error("right_z exp %0d got %0d", e.right_z, got.right_z); errors++; end
            if (got.up_x !== e.up_x)
                begin $error("up_x exp %0d got %0d", e.up_x, got.up_x); errors++; end
            if (got.up_y !== e.up_y)
                begin $error("up_y exp %0d got %0d", e.up_y, got.up_y); errors++; end
            if (got.up_z !== e.up_z)
                begin $error("up_z exp %0d got %0d", e.up_z, got.up_z); errors++; end
            if (got.facing_fallback !== e.facing_fallback)
            begin
                $error("facing_fallback exp %0b got %0b", e.facing_fallback,
                       got.facing_fallback);
                errors++;
            end
            if (got.right_fallback !== e.right_fallback)
            begin
                $error("right_fallback exp %0b got %0b", e.right_fallback,
                       got.right_fallback);
                errors++;
            end
        endfunction
    endclass

    basis_scoreboard sb;

    // Clock.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Results are sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (result.facing_fallback || result.right_fallback)
                fallback_seen++;
            sb.check_basis(result);
        end
    end

    // Issues one pose, with random idle cycles before it.
    task automatic send_pose(input lacb_in_t p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_pose(predict_basis(p, min_len_sq));
        items_sent++;
        @(negedge clk);
    endtask

    // Lowers start and waits until the pipeline has drained.
    task automatic drain_pipe();
        start <= 1'b0;
        while (sb.pending_bases.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [31:0] thr);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(negedge clk);
        cfg_we    <= 1'b0;
        min_len_sq = thr;
    endtask

    function automatic lacb_in_t pose_from(input int px, input int py, input int pz,
                                           input int tx, input int ty, input int tz);
        lacb_in_t p;
        p.position_x = px;
        p.position_y = py;
        p.position_z = pz;
        p.target_x = tx;
        p.target_y = ty;
        p.target_z = tz;
        return p;
    endfunction

    // Random pose; mostly short offsets, sometimes full range or near-degenerate.
    function automatic lacb_in_t random_pose();
        lacb_in_t p;
        int kind;
        int sh;
        kind = $urandom_range(9);
        p.position_x = $urandom;
        p.position_y = $urandom;
        p.position_z = $urandom;
        if (kind < 2)
        begin
            p.target_x = $urandom;
            p.target_y = $urandom;
            p.target_z = $urandom;
        end
        else
        begin
            sh = (kind == 2) ? 2 : $urandom_range(24, 4);
            p.target_x = p.position_x + ($signed($urandom) >>> (32 - sh));
            p.target_y = p.position_y + ($signed($urandom) >>> (32 - sh));
            p.target_z = p.position_z + ($signed($urandom) >>> (32 - sh));
            // Straight up or down, where right degenerates.
            if (kind == 3)
            begin
                p.target_x = p.position_x + $signed($urandom_range(2)) - 1;
                p.target_z = p.position_z + $signed($urandom_range(2)) - 1;
            end
        end
        return p;
    endfunction

    task automatic random_phase(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
            send_pose(random_pose());
    endtask

    localparam int MAXI = 32'h7FFFFFFF;
    localparam int MINI = 32'h80000000;

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        min_len_sq = MIN_LEN_SQ_RESET;
        sender_idle_pct = 0;
        items_sent = 0;
        fallback_seen = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed poses at the reset threshold.
        send_pose(pose_from(0, 0, 0, 0, 0, 0));
        send_pose(pose_from(MINI, MINI, MINI, MAXI, MAXI, MAXI));
        send_pose(pose_from(MAXI, MAXI, MAXI, MINI, MINI, MINI));
        send_pose(pose_from(0, 0, 0, 0, 65536, 0));
        send_pose(pose_from(0, 0, 0, 0, -65536, 0));
        send_pose(pose_from(0, 0, 0, 65536, 0, 0));
        send_pose(pose_from(0, 0, 0, 0, 0, -65536));
        send_pose(pose_from(0, 0, 0, 0, 0, 65536));
        send_pose(pose_from(0, 0, 0, 1, 0, 0));
        send_pose(pose_from(0, 0, 0, 655, 0, 0));
        send_pose(pose_from(0, 0, 0, 656, 0, 0));
        send_pose(pose_from(-1, -1, -1, 1, 1, 1));
        send_pose(pose_from(0, 0, 0, 1, 65536, 0));
        drain_pipe();

        // Zero threshold: only exact zeros fall back.
        write_threshold(32'd0);
        send_pose(pose_from(5, 5, 5, 5, 5, 5));
        send_pose(pose_from(0, 0, 0, 1, 0, 0));
        send_pose(pose_from(0, 0, 0, 0, 7, 0));
        send_pose(pose_from(0, 0, 0, 0, -1, 0));
        send_pose(pose_from(MAXI, 0, MINI, MINI, 0, MAXI));
        random_phase(60, 0);
        drain_pipe();

        // Largest threshold: every difference of squared length below 0xFFFFFFFF falls back.
        write_threshold(LEN_SQ_MAX);
        send_pose(pose_from(MINI, MINI, MINI, MAXI, MAXI, MAXI));
        random_phase(40, 81);
        drain_pipe();

        write_threshold($urandom);
        random_phase(60, 26);
        drain_pipe();

        write_threshold(MIN_LEN_SQ_RESET);
        random_phase(140, 0);
        random_phase(60, 81);
        drain_pipe();

        write_threshold($urandom_range(32'h00100000));
        random_phase(60, 26);
        drain_pipe();

        $display("Sent %0d poses over six threshold settings; checked %0d results, %0d with a fallback.",
                 items_sent, sb.checked, fallback_seen);
        if (sb.errors == 0 && sb.pending_bases.size() == 0)
            $display("look_at_camera_basis test passed");
        else
            $display("look_at_camera_basis test failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("look_at_camera_basis test failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/lacb_pkg.sv
src/lacb_norm3.sv
src/look_at_camera_basis.sv
src/lacb_checker.sv
tb/look_at_camera_basis_tb.sv
